FILE: src/bit_unpack_codebook_dequantizer_defines.svh
// Assertion macros for the bit unpack codebook dequantizer.
// Included by the top level; no other dependencies.
`ifndef BIT_UNPACK_CODEBOOK_DEQUANTIZER_DEFINES_SVH
`define BIT_UNPACK_CODEBOOK_DEQUANTIZER_DEFINES_SVH

// Checked property, masked while reset is high.
`define BUCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds across reset.
`define BUCD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/bucd_pkg.sv
// Shared constants for the bit unpack codebook dequantizer.
// No dependencies.
`timescale 1ns / 1ps

package bucd_pkg;

  localparam int CODE_BITS_DEF = 7;
  localparam int BYTE_W        = 8;

  // tuser kind of an input beat
  localparam logic FUNC_STREAM = 1'b0;
  localparam logic FUNC_WRITE  = 1'b1;

endpackage

FILE: src/bit_unpack_codebook_dequantizer.sv
// Channel   Dir  tdata (low bit up)                               tuser   tlast
// s_        in   stream_byte[7:0] entry_index[15:8] entry_value[23:16]  func    -
// m_        out  pixel[7:0]                                       -       last
//
// A stream byte yields one code per cycle from the bit buffer while the output is
// free; with 7-bit codes a byte yields 1 or 2 codes (floor((held+8)/CODE_BITS) in
// general), one code per cycle set by the single codebook read port. Pixel is
// registered and appears in the cycle after its code is taken. rst clears the bit
// buffer count and output valid; the codebook is not cleared. A stalled output
// holds the extractor, but a beat is still accepted while the last pixel waits.
//
// Top level; uses bucd_pkg and bit_unpack_codebook_dequantizer_defines.svh.
`timescale 1ns / 1ps
`include "bit_unpack_codebook_dequantizer_defines.svh"

module bit_unpack_codebook_dequantizer
  import bucd_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // stream_byte, entry_index, entry_value
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // pixel
  output logic        m_tlast    // last
);

  localparam int HELD_W   = $clog2(CODE_BITS + BYTE_W);
  localparam int CB_DEPTH = 1 << CODE_BITS;
  localparam int BUF_W    = 2 * BYTE_W;
  localparam logic [HELD_W-1:0] N_H    = HELD_W'(CODE_BITS);
  localparam logic [HELD_W-1:0] BYTE_H = HELD_W'(BYTE_W);

  logic [BUF_W-1:0]     bit_buf;
  logic [HELD_W-1:0]    held;
  logic [HELD_W-1:0]    held_rem;
  logic [HELD_W-1:0]    shift;
  logic [BUF_W-1:0]     code_wide;
  logic [CODE_BITS-1:0] code;
  logic                 do_ext;
  logic                 in_acc;
  logic                 wr_en;
  logic [BYTE_W-1:0]    stream_byte;
  logic [BYTE_W-1:0]    entry_index;
  logic [BYTE_W-1:0]    entry_value;
  logic [BYTE_W-1:0]    pixel;
  logic                 last;
  logic                 out_valid;
  logic [BYTE_W-1:0]    cb_mem [CB_DEPTH];

  assign stream_byte = s_tdata[7:0];
  assign entry_index = s_tdata[15:8];
  assign entry_value = s_tdata[23:16];

  // one code leaves the buffer per cycle when the output stage is free
  always_comb begin
    do_ext    = (held >= N_H) && (!out_valid || m_tready);
    shift     = held - N_H;
    code_wide = bit_buf >> shift;
    code      = code_wide[CODE_BITS-1:0];
    held_rem  = do_ext ? shift : held;
  end

  // take a beat only once the buffer has no code left beyond this cycle
  assign s_tready = held_rem < N_H;
  assign in_acc   = s_tvalid && s_tready;
  assign wr_en    = in_acc && (s_tuser == FUNC_WRITE) &&
                    ((entry_index >> CODE_BITS) == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc && s_tuser == FUNC_STREAM) begin
        held <= held_rem + BYTE_H;
      end else begin
        held <= held_rem;
      end
      if (do_ext) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && s_tuser == FUNC_STREAM) begin
      bit_buf <= {bit_buf[BYTE_W-1:0], stream_byte};
    end
    if (do_ext) begin
      last <= shift < N_H;
    end
  end

  // codebook: write on a write beat whose index fits the codebook, registered read for the extracted code
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cb_mem[entry_index[CODE_BITS-1:0]] <= entry_value;
    end
    if (do_ext) begin
      pixel <= cb_mem[code];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = pixel;
  assign m_tlast  = last;

  `BUCD_ASSERT(a_held_bound, held < N_H + BYTE_H, "bit count out of range")
  `BUCD_ASSERT(a_byte_gives_code, (in_acc && s_tuser == FUNC_STREAM) |=> held >= N_H,
               "stream byte gave no code")
  `BUCD_ASSERT(a_ext_valid, do_ext |=> m_tvalid, "extracted code lost")
  `BUCD_ASSERT_RST(a_rst_clear, rst |=> !m_tvalid && held == '0, "reset left state")

endmodule
